[design/splg_pkg.sv]
// Shared types, constants and table functions of the stereo pan-law gain unit.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none
package splg_pkg;

  localparam int unsigned SampleBits = 24;
  localparam int unsigned GainBits   = 32;
  localparam int unsigned PanBits    = 17;
  localparam int unsigned RampBits   = 16;
  localparam int unsigned CntBits    = 5;

  localparam logic [GainBits-1:0] GainOne  = 32'h4000_0000;
  localparam logic [GainBits-1:0] GainHalf = 32'h2000_0000;
  localparam logic [63:0]         HalfPiQ32 = 64'd6746518852;

  localparam logic [1:0] LawLinear  = 2'd0;
  localparam logic [1:0] LawPower   = 2'd1;
  localparam logic [1:0] LawSqrt    = 2'd2;
  localparam logic [1:0] LawBalance = 2'd3;

  localparam logic [1:0] RegPan  = 2'd0;
  localparam logic [1:0] RegLaw  = 2'd1;
  localparam logic [1:0] RegRamp = 2'd2;

  localparam logic signed [PanBits-1:0] PanReset  = 17'sd0;
  localparam logic [1:0]                LawReset  = LawPower;
  localparam logic [RampBits-1:0]       RampReset = 16'd2400;

  typedef struct packed {
    logic signed [SampleBits-1:0] left_in;
    logic signed [SampleBits-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] left_out;
    logic signed [SampleBits-1:0] right_out;
  } out_t;

  typedef struct packed {
    logic signed [PanBits-1:0] pan;
    logic [1:0]                law;
    logic [RampBits-1:0]       ramp;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic tgt_load;
    logic sqrt_step;
    logic tgt_sel;
    logic jump;
    logic div_load;
    logic div_step;
    logic set_step;
    logic advance;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_sqrt;
    logic cnt_zero;
    logic retarget;
    logic ramp_zero;
  } sts_t;

  // Truncated Taylor series of sin in unsigned Q1.30, clamped to [0, 1.0].
  function automatic logic [30:0] sine_q30(input logic [63:0] a);
    logic [63:0]        t;
    logic signed [65:0] s;
    t = a;
    s = $signed({2'b00, a});
    for (int k = 1; k <= 8; k++) begin
      t  = (t * a) >> 30;
      t  = (t * a) >> 30;
      t  = t / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        s = s - $signed({2'b00, t});
      end else begin
        s = s + $signed({2'b00, t});
      end
    end
    if (s < 0) begin
      s = '0;
    end
    if (s > $signed({34'd0, GainOne})) begin
      s = $signed({34'd0, GainOne});
    end
    return s[30:0];
  endfunction

  function automatic logic [30:0] sine_entry(input int unsigned k, input int unsigned tb);
    logic [63:0] a;
    a = ((64'(k) * HalfPiQ32) >> tb) >> 2;
    return sine_q30(a);
  endfunction

endpackage
`default_nettype wire

[design/splg_ctrl.sv]
// Sequencing state machine of the stereo pan-law gain unit.
// Depends on splg_pkg for the command and status structs.
`default_nettype none
module splg_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire splg_pkg::sts_t sts_i,
  output splg_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StTgt  = 4'd1;
  localparam logic [3:0] StSqrt = 4'd2;
  localparam logic [3:0] StSel  = 4'd3;
  localparam logic [3:0] StCmp  = 4'd4;
  localparam logic [3:0] StDiv  = 4'd5;
  localparam logic [3:0] StSet  = 4'd6;
  localparam logic [3:0] StAdv  = 4'd7;
  localparam logic [3:0] StMul  = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StTgt;
        end
      end
      StTgt: begin
        cmd_o.tgt_load = 1'b1;
        state_d        = sts_i.need_sqrt ? StSqrt : StSel;
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.cnt_zero) begin
          state_d = StSel;
        end
      end
      StSel: begin
        cmd_o.tgt_sel = 1'b1;
        state_d       = StCmp;
      end
      StCmp: begin
        if (!sts_i.retarget) begin
          state_d = StAdv;
        end else if (sts_i.ramp_zero) begin
          cmd_o.jump = 1'b1;
          state_d    = StAdv;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_zero) begin
          state_d = StSet;
        end
      end
      StSet: begin
        cmd_o.set_step = 1'b1;
        state_d        = StAdv;
      end
      StAdv: begin
        cmd_o.advance = 1'b1;
        state_d       = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[design/splg_datapath.sv]
// Datapath of the stereo pan-law gain unit: target gains, square root and
// ramp divider iterations, gain ramp and output scaling. Depends on splg_pkg.
`default_nettype none
module splg_datapath #(
  parameter int unsigned TABLE_BITS = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire splg_pkg::cfg_t cfg_i,
  input  wire splg_pkg::in_t  in_data_i,
  input  wire splg_pkg::cmd_t cmd_i,
  output splg_pkg::sts_t      sts_o,
  output splg_pkg::out_t      out_data_o
);

  localparam int unsigned SB       = splg_pkg::SampleBits;
  localparam int unsigned GB       = splg_pkg::GainBits;
  localparam int unsigned TabLen   = (1 << TABLE_BITS) + 1;
  localparam int unsigned IdxBits  = TABLE_BITS + 1;
  localparam int unsigned FracBits = 16 - TABLE_BITS;
  localparam int unsigned ProdBits = SB + GB;
  localparam int unsigned RndBits  = ProdBits - 30;
  localparam int unsigned IpBits   = GB + FracBits + 1;
  localparam logic signed [RndBits-1:0] SatHi = RndBits'((1 << (SB - 1)) - 1);
  localparam logic signed [RndBits-1:0] SatLo = -RndBits'(1 << (SB - 1));

  logic [30:0] sine_tab [TabLen];

  for (genvar g = 0; g < TabLen; g++) begin : g_tab
    localparam logic [30:0] Val = splg_pkg::sine_entry(g, TABLE_BITS);
    assign sine_tab[g] = Val;
  end

  splg_pkg::in_t in_q;
  logic [splg_pkg::CntBits-1:0]  cnt_q;
  logic [splg_pkg::RampBits-1:0] sl_q;
  logic [16:0] pos_x;
  logic [16:0] lane_x [2];
  logic [GB-1:0] bal [2];
  logic signed [SB-1:0] smp [2];
  logic signed [GB-1:0] tgt_q [2], goal_q [2], now_q [2], step_q [2];
  logic signed [ProdBits-1:0] prod_q [2];
  logic signed [SB-1:0] res_out [2];

  assign pos_x     = 17'(18'($signed(cfg_i.pan)) + 18'd32768);
  assign lane_x[0] = 17'd65536 - pos_x;
  assign lane_x[1] = pos_x;
  assign bal[0]    = (cfg_i.pan <= 0) ? splg_pkg::GainOne : {lane_x[0], 15'd0};
  assign bal[1]    = (cfg_i.pan >= 0) ? splg_pkg::GainOne : {lane_x[1], 15'd0};
  assign smp[0]    = in_q.left_in;
  assign smp[1]    = in_q.right_in;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [IdxBits-1:0]  idx, idx_n;
    logic [FracBits-1:0] frac;
    logic                tab_end;
    logic [30:0]         base_q, nxt_q;
    logic [FracBits-1:0] frac_q;
    logic                use_base_q;
    logic signed [GB-1:0]     ip_diff;
    logic signed [IpBits-1:0] ip_prod, ip_adj;
    logic signed [GB-1:0]     sine_val;
    logic [61:0] rad_q;
    logic [33:0] rem_q;
    logic [30:0] root_q;
    logic [35:0] rn, trial;
    logic [31:0] dnum_q, dq_q;
    logic [15:0] drem_q;
    logic        dneg_q;
    logic [16:0] r2;
    logic signed [GB:0] diff;
    logic [GB-1:0] tsel;
    logic signed [RndBits-1:0] rnd;
    logic signed [ProdBits-1:0] rsum;

    assign idx     = lane_x[l][16:FracBits];
    assign frac    = lane_x[l][FracBits-1:0];
    assign tab_end = (idx == IdxBits'(TabLen - 1));
    assign idx_n   = tab_end ? idx : idx + 1'b1;

    assign ip_diff  = $signed({1'b0, nxt_q}) - $signed({1'b0, base_q});
    assign ip_prod  = IpBits'(ip_diff) * $signed({1'b0, frac_q});
    assign ip_adj   = ip_prod + ((ip_prod < 0) ? IpBits'((1 << FracBits) - 1) : '0);
    assign sine_val = use_base_q ? $signed({1'b0, base_q})
                                 : $signed({1'b0, base_q}) + GB'(ip_adj >>> FracBits);

    assign rn    = {rem_q, rad_q[61:60]};
    assign trial = {3'd0, root_q, 2'b01};
    assign r2    = {drem_q, dnum_q[31]};
    assign diff  = $signed({tgt_q[l][GB-1], tgt_q[l]}) - $signed({now_q[l][GB-1], now_q[l]});

    always_comb begin
      case (cfg_i.law)
        splg_pkg::LawLinear:  tsel = GB'({lane_x[l], 14'd0});
        splg_pkg::LawPower:   tsel = sine_val;
        splg_pkg::LawSqrt:    tsel = {1'b0, root_q};
        splg_pkg::LawBalance: tsel = bal[l];
        default:              tsel = bal[l];
      endcase
    end

    assign rsum = prod_q[l] + ProdBits'(1 << 29);
    assign rnd  = rsum[ProdBits-1:30];
    always_comb begin
      if (rnd > SatHi) begin
        res_out[l] = SatHi[SB-1:0];
      end else if (rnd < SatLo) begin
        res_out[l] = SatLo[SB-1:0];
      end else begin
        res_out[l] = rnd[SB-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.tgt_load) begin
        base_q     <= sine_tab[idx];
        nxt_q      <= sine_tab[idx_n];
        frac_q     <= frac;
        use_base_q <= (frac == '0) || tab_end;
        rad_q      <= {1'b0, lane_x[l], 44'd0};
        rem_q      <= '0;
        root_q     <= '0;
      end else if (cmd_i.sqrt_step) begin
        rad_q <= {rad_q[59:0], 2'b00};
        if (rn >= trial) begin
          rem_q  <= 34'(rn - trial);
          root_q <= {root_q[29:0], 1'b1};
        end else begin
          rem_q  <= rn[33:0];
          root_q <= {root_q[29:0], 1'b0};
        end
      end
      if (cmd_i.div_load) begin
        dneg_q <= diff[GB];
        dnum_q <= diff[GB] ? 32'(-diff) : 32'(diff);
        drem_q <= '0;
        dq_q   <= '0;
      end else if (cmd_i.div_step) begin
        dnum_q <= {dnum_q[30:0], 1'b0};
        if (r2 >= {1'b0, cfg_i.ramp}) begin
          drem_q <= 16'(r2 - {1'b0, cfg_i.ramp});
          dq_q   <= {dq_q[30:0], 1'b1};
        end else begin
          drem_q <= r2[15:0];
          dq_q   <= {dq_q[30:0], 1'b0};
        end
      end
      if (cmd_i.tgt_sel) begin
        tgt_q[l] <= $signed(tsel);
      end
      if (cmd_i.set_step) begin
        step_q[l] <= dneg_q ? -$signed(dq_q) : $signed(dq_q);
      end
      if (cmd_i.mul) begin
        prod_q[l] <= ProdBits'(smp[l]) * ProdBits'(now_q[l]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        now_q[l]  <= $signed(splg_pkg::GainHalf);
        goal_q[l] <= $signed(splg_pkg::GainHalf);
      end else if (cmd_i.jump) begin
        now_q[l]  <= tgt_q[l];
        goal_q[l] <= tgt_q[l];
      end else if (cmd_i.div_load) begin
        goal_q[l] <= tgt_q[l];
      end else if (cmd_i.advance && sl_q != '0) begin
        now_q[l] <= (sl_q != 16'd1) ? now_q[l] + step_q[l] : goal_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.tgt_load) begin
      cnt_q <= splg_pkg::CntBits'(30);
    end else if (cmd_i.div_load) begin
      cnt_q <= splg_pkg::CntBits'(31);
    end else if (cmd_i.sqrt_step || cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.out_load) begin
      out_data_o.left_out  <= res_out[0];
      out_data_o.right_out <= res_out[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_q <= '0;
    end else if (cmd_i.jump) begin
      sl_q <= '0;
    end else if (cmd_i.set_step) begin
      sl_q <= cfg_i.ramp;
    end else if (cmd_i.advance && sl_q != '0) begin
      sl_q <= sl_q - 1'b1;
    end
  end

  assign sts_o.need_sqrt = (cfg_i.law == splg_pkg::LawSqrt);
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.retarget  = (tgt_q[0] != goal_q[0]) || (tgt_q[1] != goal_q[1]);
  assign sts_o.ramp_zero = (cfg_i.ramp == '0);

endmodule
`default_nettype wire

[design/stereo_pan_law_smoothed_gain_unit.sv]
// Top level of the stereo pan-law gain unit: register port and the joining of
// controller and datapath. Depends on splg_pkg, splg_ctrl and splg_datapath.
//
//   port group  | direction | transfer when
//   in_*        | in        | in_valid_i && in_ready_o (one stereo pair)
//   out_*       | out       | out_valid_o && out_ready_i (one scaled pair)
//   p*          | in/out    | psel && penable && pwrite (register write)
//
// A pair passes the target, select, compare, advance, multiply and output
// states; the square root law adds its 31-step root unit, and a new target
// that starts a ramp adds the 32-step divider. Reset puts both gains at one
// half with no ramp running. A result waits in the output register while the
// next pair is taken; only the final load waits for that register to empty.
`default_nettype none
module stereo_pan_law_smoothed_gain_unit #(
  parameter int unsigned TABLE_BITS = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire splg_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output splg_pkg::out_t     out_data_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  splg_pkg::cfg_t cfg_q;
  splg_pkg::cmd_t cmd;
  splg_pkg::sts_t sts;
  logic signed [splg_pkg::PanBits-1:0] wr_pan, pan_clamped;

  assign pready = 1'b1;
  assign wr_pan = $signed(pwdata[splg_pkg::PanBits-1:0]);

  always_comb begin
    if (wr_pan < -17'sd32768) begin
      pan_clamped = -17'sd32768;
    end else if (wr_pan > 17'sd32768) begin
      pan_clamped = 17'sd32768;
    end else begin
      pan_clamped = wr_pan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pan  <= splg_pkg::PanReset;
      cfg_q.law  <= splg_pkg::LawReset;
      cfg_q.ramp <= splg_pkg::RampReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        splg_pkg::RegPan:  cfg_q.pan  <= pan_clamped;
        splg_pkg::RegLaw:  cfg_q.law  <= pwdata[1:0];
        splg_pkg::RegRamp: cfg_q.ramp <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      splg_pkg::RegPan:  prdata = 32'($signed(cfg_q.pan));
      splg_pkg::RegLaw:  prdata = {30'd0, cfg_q.law};
      splg_pkg::RegRamp: prdata = {16'd0, cfg_q.ramp};
      default:           prdata = '0;
    endcase
  end

  splg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  splg_datapath #(
    .TABLE_BITS (TABLE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after an input transfer");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result loaded while the unit was idle");

  a_pan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.pan >= -17'sd32768) && (cfg_q.pan <= 17'sd32768))
    else $error("pan position outside its clamped range");

endmodule
`default_nettype wire

[dv/stereo_pan_law_smoothed_gain_unit_test.sv]
// Self-checking testbench of the stereo pan-law gain unit: directed and random
// stereo pairs under changing pan, law and ramp settings. Depends on splg_pkg
// and the unit's RTL only.
`default_nettype none
module stereo_pan_law_smoothed_gain_unit_test;

  localparam int TabLen = 257;
  localparam int WatchLimit = 20000;
  localparam int IdleWait = 120;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  splg_pkg::in_t in_data_i;
  splg_pkg::out_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  stereo_pan_law_smoothed_gain_unit dut (.*);

  splg_pkg::in_t pend_pairs[$];
  splg_pkg::out_t exp_pairs[$];
  int errors = 0;
  int idle_mode = 2;
  int quiet_cycles = 0;

  int sin_tab[TabLen];
  int pan_q15;
  int unsigned law_sel, ramp_len;
  int left_now, right_now, left_goal, right_goal, left_inc, right_inc;
  int unsigned steps_rem;

  function automatic int taylor_sine(longint unsigned a);
    longint unsigned t;
    longint s;
    t = a;
    s = longint'(a);
    for (int k = 1; k <= 8; k++) begin
      t = (t * a) >> 30;
      t = (t * a) >> 30;
      t = t / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s -= longint'(t);
      else s += longint'(t);
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    return int'(s);
  endfunction

  function automatic int sine_gain(int unsigned x);
    int unsigned idx, frac;
    longint diff;
    idx = x >> 8;
    frac = x & 255;
    if (idx >= TabLen) idx = TabLen - 1;
    if (frac == 0 || idx + 1 >= TabLen) return sin_tab[idx];
    diff = longint'(sin_tab[idx + 1]) - longint'(sin_tab[idx]);
    return int'(longint'(sin_tab[idx]) + (diff * longint'(frac)) / 256);
  endfunction

  function automatic int root_gain(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return int'(res);
  endfunction

  function automatic logic signed [23:0] apply_gain(logic signed [23:0] smp, int g);
    longint r;
    r = (longint'(smp) * longint'(g) + 64'sd536870912) >>> 30;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[23:0];
  endfunction

  task automatic predict_pair(splg_pkg::in_t p);
    int unsigned x, xl;
    int tl, tr;
    splg_pkg::out_t o;
    x = int'(pan_q15 + 32768);
    xl = 65536 - x;
    case (law_sel[1:0])
      splg_pkg::LawLinear: begin
        tl = int'(xl << 14);
        tr = int'(x << 14);
      end
      splg_pkg::LawPower: begin
        tl = sine_gain(xl);
        tr = sine_gain(x);
      end
      splg_pkg::LawSqrt: begin
        tl = root_gain(longint'(xl) << 44);
        tr = root_gain(longint'(x) << 44);
      end
      default: begin
        tl = (pan_q15 <= 0) ? int'(splg_pkg::GainOne) : int'(xl << 15);
        tr = (pan_q15 >= 0) ? int'(splg_pkg::GainOne) : int'(x << 15);
      end
    endcase
    if (tl != left_goal || tr != right_goal) begin
      left_goal = tl;
      right_goal = tr;
      if (ramp_len == 0) begin
        left_now = tl;
        right_now = tr;
        steps_rem = 0;
      end else begin
        left_inc = int'((longint'(tl) - longint'(left_now)) / longint'(ramp_len));
        right_inc = int'((longint'(tr) - longint'(right_now)) / longint'(ramp_len));
        steps_rem = ramp_len;
      end
    end
    if (steps_rem > 0) begin
      steps_rem--;
      if (steps_rem > 0) begin
        left_now += left_inc;
        right_now += right_inc;
      end else begin
        left_now = left_goal;
        right_now = right_goal;
      end
    end
    o.left_out = apply_gain(p.left_in, left_now);
    o.right_out = apply_gain(p.right_in, right_now);
    exp_pairs.push_back(o);
  endtask

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pend_pairs.size() > 0 &&
          !(idle_mode == 0 && $urandom_range(99) < 12) &&
          !(idle_mode == 1 && $urandom_range(99) < 75)) begin
        in_valid_i <= 1'b1;
        in_data_i <= pend_pairs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (idle_mode == 0) out_ready_i <= $urandom_range(99) >= 75;
    else if (idle_mode == 1) out_ready_i <= $urandom_range(99) >= 12;
    else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_pair(in_data_i);
      if (out_valid_o && out_ready_i) begin
        if (exp_pairs.size() == 0) begin
          report_mismatch("unexpected transfer", out_data_o.left_out, 24'h000000);
        end else begin
          splg_pkg::out_t w;
          w = exp_pairs.pop_front();
          if (out_data_o.left_out !== w.left_out)
            report_mismatch("left_out", out_data_o.left_out, w.left_out);
          if (out_data_o.right_out !== w.right_out)
            report_mismatch("right_out", out_data_o.right_out, w.right_out);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("stereo_pan_law_smoothed_gain_unit test failed");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      splg_pkg::RegPan: begin
        pan_q15 = int'($signed(val[16:0]));
        if (pan_q15 < -32768) pan_q15 = -32768;
        if (pan_q15 > 32768) pan_q15 = 32768;
      end
      splg_pkg::RegLaw: law_sel = val[1:0];
      splg_pkg::RegRamp: ramp_len = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pend_pairs.size() > 0 || in_valid_i || exp_pairs.size() > 0) @(negedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic queue_pairs(int n);
    splg_pkg::in_t p;
    for (int i = 0; i < n; i++) begin
      p.left_in = rand_sample();
      p.right_in = rand_sample();
      pend_pairs.push_back(p);
    end
  endtask

  function automatic logic [31:0] rand_pan();
    int v;
    case ($urandom_range(7))
      0: v = -32768;
      1: v = 32768;
      2: v = 0;
      3: v = $urandom_range(65535) - 65536;
      default: v = $urandom_range(65536) - 32768;
    endcase
    return 32'(v);
  endfunction

  function automatic logic [31:0] rand_ramp();
    logic [31:0] hi;
    hi = {16'($urandom_range(65535)), 16'h0};
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd65535;
      3: return hi | $urandom_range(65535);
      default: return hi | $urandom_range(1, 40);
    endcase
  endfunction

  initial begin
    splg_pkg::in_t p;
    for (int k = 0; k < TabLen; k++)
      sin_tab[k] = taylor_sine(((longint'(k) * longint'(splg_pkg::HalfPiQ32)) >> 8) >> 2);
    pan_q15 = 0;
    law_sel = 1;
    ramp_len = 2400;
    left_now = int'(splg_pkg::GainHalf);
    right_now = int'(splg_pkg::GainHalf);
    left_goal = int'(splg_pkg::GainHalf);
    right_goal = int'(splg_pkg::GainHalf);
    left_inc = 0;
    right_inc = 0;
    steps_rem = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, then each law at both pan ends with an instant jump.
    p.left_in = 24'h7FFFFF;
    p.right_in = 24'h800000;
    pend_pairs.push_back(p);
    p.left_in = 24'h800000;
    p.right_in = 24'h7FFFFF;
    pend_pairs.push_back(p);
    drain();
    reg_write(splg_pkg::RegRamp, 32'd0);
    for (int l = 0; l < 4; l++) begin
      reg_write(splg_pkg::RegLaw, 32'(l));
      reg_write(splg_pkg::RegPan, 32'hFFFF_0000);
      pend_pairs.push_back(p);
      queue_pairs(1);
      drain();
      reg_write(splg_pkg::RegPan, 32'h0000_FFFF);
      pend_pairs.push_back(p);
      queue_pairs(1);
      drain();
    end
    // Pan change on a short ramp, then a ramp length change mid-ramp.
    reg_write(splg_pkg::RegLaw, 32'(splg_pkg::LawBalance));
    reg_write(splg_pkg::RegRamp, 32'd3);
    reg_write(splg_pkg::RegPan, 32'hFFFF_C000);
    queue_pairs(2);
    drain();
    reg_write(splg_pkg::RegRamp, 32'd1);
    reg_write(2'd3, 32'hFFFF_FFFF);
    queue_pairs(2);
    drain();

    for (int ph = 0; ph < 21; ph++) begin
      idle_mode = (ph < 7) ? 0 : (ph < 14) ? 1 : 2;
      if ($urandom_range(3) != 0) reg_write(splg_pkg::RegPan, rand_pan());
      if ($urandom_range(3) != 0) reg_write(splg_pkg::RegLaw, $urandom());
      if ($urandom_range(2) != 0) reg_write(splg_pkg::RegRamp, rand_ramp());
      if ($urandom_range(9) == 0) reg_write(2'd3, $urandom());
      queue_pairs(72);
      drain();
    end

    if (errors == 0) begin
      $display("stereo_pan_law_smoothed_gain_unit test passed");
    end else begin
      $display("stereo_pan_law_smoothed_gain_unit test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
design/splg_pkg.sv
design/splg_ctrl.sv
design/splg_datapath.sv
design/stereo_pan_law_smoothed_gain_unit.sv
dv/stereo_pan_law_smoothed_gain_unit_test.sv
